/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands included by the top RTL file of the dither packer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

/* rtl/od332_pkg.sv */
// ---------------------------------------------------------------------------
// od332_pkg
// Types, constants and the Bayer threshold table of the RGB 3-3-2 packer.
// ---------------------------------------------------------------------------
`default_nettype none

package od332_pkg;

  // Field and register widths
  localparam int SAMPLE_W = 8;
  localparam int PIXEL_W  = 8;
  localparam int DIM_W    = 13;
  localparam int COUNT_W  = 12;
  localparam int INDEX_W  = 1;

  // Register indexes of the configuration port
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Dimension limits and reset values
  localparam logic [DIM_W-1:0] MAX_DIMENSION = 13'd4096;
  localparam logic [DIM_W-1:0] MIN_DIMENSION = 13'd1;
  localparam logic [DIM_W-1:0] DIM_RESET     = 13'd1024;

  // Top quantization level of each channel
  localparam logic [2:0] LEVEL_MAX_RG = 3'd7;
  localparam logic [1:0] LEVEL_MAX_B  = 2'd3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [3:0]          thresh_t;

  typedef struct packed {
    sample_t blue;
    sample_t green;
    sample_t red;
  } rgb_t;

  // 4x4 Bayer thresholds, indexed by {row[1:0], column[1:0]}
  localparam thresh_t BAYER_TABLE [0:15] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  // Clamp a raw dimension register into 1..MAX_DIMENSION
  function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = MIN_DIMENSION;
    end else if (v > MAX_DIMENSION) begin
      res = MAX_DIMENSION;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/od332_quant.sv */
// ---------------------------------------------------------------------------
// od332_quant
// Scales, dithers and packs one RGB pixel into an 8-bit 3-3-2 word.
// ---------------------------------------------------------------------------
`default_nettype none

module od332_quant (
  input  od332_pkg::rgb_t    pixel,
  input  od332_pkg::thresh_t thresh,
  output logic [7:0]         packed_pixel
);
  import od332_pkg::*;

  logic [10:0] red_prod;
  logic [10:0] green_prod;
  logic [9:0]  blue_prod;
  logic [7:0]  red_t;
  logic [7:0]  green_t;
  logic [7:0]  blue_t;
  logic [2:0]  red_lvl;
  logic [2:0]  green_lvl;
  logic [1:0]  blue_lvl;
  logic        red_up;
  logic        green_up;
  logic        blue_up;

  // Scale red and green by 7/8, blue by 3/4
  assign red_prod   = ({3'b000, pixel.red} << 3) - {3'b000, pixel.red};
  assign green_prod = ({3'b000, pixel.green} << 3) - {3'b000, pixel.green};
  assign blue_prod  = ({2'b00, pixel.blue} << 1) + {2'b00, pixel.blue};
  assign red_t      = red_prod[10:3];
  assign green_t    = green_prod[10:3];
  assign blue_t     = blue_prod[9:2];

  // Step the level up when the bits below the cut beat the threshold
  assign red_up   = (red_t[7:5] != LEVEL_MAX_RG) && (red_t[4:1] > thresh);
  assign green_up = (green_t[7:5] != LEVEL_MAX_RG) && (green_t[4:1] > thresh);
  assign blue_up  = (blue_t[7:6] != LEVEL_MAX_B) && (blue_t[5:2] > thresh);

  assign red_lvl   = red_t[7:5] + {2'b00, red_up};
  assign green_lvl = green_t[7:5] + {2'b00, green_up};
  assign blue_lvl  = blue_t[7:6] + {1'b0, blue_up};

  // Red in the top bits, blue in the bottom two
  assign packed_pixel = {red_lvl, green_lvl, blue_lvl};

endmodule

`default_nettype wire

/* rtl/ordered_dither_rgb332_packer_unit.sv */
// ---------------------------------------------------------------------------
// ordered_dither_rgb332_packer_unit
// Ordered 4x4 Bayer dither of an RGB888 stream down to RGB 3-3-2 pixels.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the s_axis channel, one word per pixel
//   with red, green and blue samples in tdata. Each word leaves as one packed
//   3-3-2 pixel on the m_axis channel, in the same order.
//   The dither threshold comes from internal column and row counters that
//   wrap at image_width and image_height (cfg port, index 0 and 1). A value
//   of zero acts as one, a value above 4096 acts as 4096. Write the
//   configuration only while the stream is idle.
//   An accepted word passes the input register, then the result register,
//   before it shows on m_axis. Throughput: one pixel per cycle while
//   m_axis does not stall, set by the single pass through the quantizer
//   between the two registers.
//   Reset clears both stages, zeroes the counters and loads 1024 x 1024.
//   When m_axis stalls, the result register holds and the input register
//   still takes one more word if it is empty; after that s_axis_tready
//   drops until the receiver takes the result.
// ---------------------------------------------------------------------------
`default_nettype none

module ordered_dither_rgb332_packer_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [od332_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [od332_pkg::DIM_W-1:0]         cfg_data,
  // pixel input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,  // red_sample, green_sample, blue_sample
  // packed pixel output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata   // packed_pixel
);
  import od332_pkg::*;

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [DIM_W-1:0]   eff_width;
  logic [DIM_W-1:0]   eff_height;
  logic [COUNT_W-1:0] column_count;
  logic [COUNT_W-1:0] row_count;
  logic [DIM_W-1:0]   column_plus;
  logic [DIM_W-1:0]   row_plus;
  logic               column_wrap;
  logic               row_wrap;

  logic               in_valid;
  rgb_t               in_pixel;
  thresh_t            in_thresh;
  logic               out_ready;
  logic               in_ready;
  logic               s_fire;
  logic [7:0]         quant_pixel;

  // Handshake of the two register stages
  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign in_ready      = !in_valid || out_ready;
  assign s_axis_tready = in_ready;
  assign s_fire        = s_axis_tvalid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_width   = effective_dim(image_width);
  assign eff_height  = effective_dim(image_height);
  assign column_plus = {1'b0, column_count} + 13'd1;
  assign row_plus    = {1'b0, row_count} + 13'd1;
  assign column_wrap = column_plus >= eff_width;
  assign row_wrap    = row_plus >= eff_height;

  // Advance the raster position on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (s_fire) begin
      if (column_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_plus[COUNT_W-1:0];
      end else begin
        column_count <= column_plus[COUNT_W-1:0];
      end
    end
  end

  // Input register: samples and the threshold of their position
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_pixel.red   <= s_axis_tdata[7:0];
      in_pixel.green <= s_axis_tdata[15:8];
      in_pixel.blue  <= s_axis_tdata[23:16];
      in_thresh      <= BAYER_TABLE[{row_count[1:0], column_count[1:0]}];
    end
  end

  od332_quant u_quant (
    .pixel        (in_pixel),
    .thresh       (in_thresh),
    .packed_pixel (quant_pixel)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && out_ready) begin
      m_axis_tdata <= quant_pixel;
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_column_step, s_fire, (column_count == '0) || (column_count == $past(column_plus[COUNT_W-1:0])), "column counter skipped a position")
  `ASSERT_NEXT(a_row_hold, s_fire && !column_wrap, row_count == $past(row_count), "row counter moved without a column wrap")
  `ASSERT_NEXT(a_input_hold, in_valid && !out_ready, in_valid && $stable(in_pixel) && $stable(in_thresh), "input register lost a word under stall")
  `ASSERT_CLK(a_count_range, (column_count < MAX_DIMENSION[COUNT_W:0]) || (column_count == '0), "column counter out of range")

endmodule

`default_nettype wire

/* tb/tb_ordered_dither_rgb332_packer_unit.sv */
// ----------------------------------------------------------------------------
// RGB 3-3-2 ordered dither packer testbench
// Streams RGB888 pixels through the packer under several image geometries
// and idle patterns. Every packed pixel that comes out is checked against
// a local Bayer dither calculation that tracks its own raster position.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ordered_dither_rgb332_packer_unit;
  import od332_pkg::*;

  localparam int NUM_GEOMETRIES = 12;
  localparam int PIXELS_PER_GEOMETRY = 146;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_DIM = 4096;

  // Bayer thresholds, indexed by row mod 4 times four plus column mod 4
  localparam int DITHER_THRESH [0:15] = '{
    0, 8, 2, 10, 12, 4, 14, 6, 3, 11, 1, 9, 15, 7, 13, 5
  };

  // Geometry plan: zero, oversized and shrink-in-place sizes included
  localparam logic [DIM_W-1:0] WIDTH_PLAN [0:NUM_GEOMETRIES-1] = '{
    13'd0, 13'd5, 13'd8191, 13'd3, 13'd4096, 13'd1,
    13'd7, 13'd4097, 13'd2, 13'd6, 13'd4, 13'd9
  };
  localparam logic [DIM_W-1:0] HEIGHT_PLAN [0:NUM_GEOMETRIES-1] = '{
    13'd4096, 13'd3, 13'd2, 13'd0, 13'd4096, 13'd1,
    13'd5, 13'd6, 13'd8191, 13'd4, 13'd1, 13'd7
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata = '0;  // red_sample, green_sample, blue_sample
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;       // packed_pixel

  // Stimulus and expectation stores
  rgb_t       rgb_to_send [$];
  logic [7:0] packed_pixels_due [$];

  // Predictor state: raw register copies and raster position
  int width_reg = 1024;
  int height_reg = 1024;
  int col_pos = 0;
  int row_pos = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int pixels_checked = 0;
  int idle_cycles = 0;

  ordered_dither_rgb332_packer_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Clamp a raw dimension register into the range the block uses
  function automatic int limit_dim(input int v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Raise a cut level by one step when the fraction beats the threshold
  function automatic int quant_channel(input int level, input int top, input int step,
                                       input int frac, input int thr);
    if (level != top && frac > thr) return level + step;
    return level;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return sample_t'($urandom_range(255));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until nothing is queued, in flight or owed by the block
  task automatic wait_drained();
    while (rgb_to_send.size() != 0 || s_axis_tvalid || packed_pixels_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_pixel(input sample_t r, input sample_t g, input sample_t b);
    rgb_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    rgb_to_send.push_back(px);
  endtask

  // Drive pixel words; predict each one as it is accepted
  always @(posedge clk) begin : drive_blk
    rgb_t px;
    int t, thr, r, g, b;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        px = rgb_to_send.pop_front();
        thr = DITHER_THRESH[(row_pos % 4) * 4 + (col_pos % 4)];
        t = (int'(px.red) * 7) >> 3;
        r = quant_channel(t & 'he0, 'he0, 'h20, (t >> 1) & 'hf, thr);
        t = (int'(px.green) * 7) >> 3;
        g = quant_channel((t >> 3) & 'h1c, 'h1c, 4, (t >> 1) & 'hf, thr);
        t = (int'(px.blue) * 3) >> 2;
        b = quant_channel((t >> 6) & 3, 3, 1, (t >> 2) & 'hf, thr);
        packed_pixels_due.push_back(8'(r | g | b));
        // advance raster position, wrapping at the effective sizes
        if (col_pos + 1 >= limit_dim(width_reg)) begin
          col_pos = 0;
          if (row_pos + 1 >= limit_dim(height_reg)) row_pos = 0;
          else row_pos = row_pos + 1;
        end else begin
          col_pos = col_pos + 1;
        end
      end
      // hold a word that was not taken; otherwise offer the next or idle
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (rgb_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= rgb_to_send[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each packed pixel against the oldest prediction
  always @(posedge clk) begin : check_blk
    logic [7:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (packed_pixels_due.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %02h with nothing pending", m_axis_tdata));
      end else begin
        want = packed_pixels_due.pop_front();
        if (m_axis_tdata !== want)
          report_mismatch($sformatf("packed_pixel got %02h want %02h (pixel %0d)",
                                    m_axis_tdata, want, pixels_checked));
        pixels_checked++;
      end
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 65;

    // Channel extremes at the reset geometry
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hff, 8'hff, 8'hff);
    queue_pixel(8'hff, 8'h00, 8'h00);
    queue_pixel(8'h00, 8'hff, 8'h00);
    queue_pixel(8'h00, 8'h00, 8'hff);
    queue_pixel(8'h55, 8'haa, 8'h80);
    wait_drained();
    repeat (3) @(posedge clk);

    // Gray ramp over a 4x4 image to hit every threshold
    write_reg(REG_IMAGE_WIDTH, 13'd4);
    write_reg(REG_IMAGE_HEIGHT, 13'd4);
    for (int i = 0; i < 17; i++)
      queue_pixel(sample_t'(i * 15), sample_t'(i * 15), sample_t'(i * 15));

    // Random pixels under each geometry; counters carry across rewrites
    for (int p = 0; p < NUM_GEOMETRIES; p++) begin
      wait_drained();
      repeat (3) @(posedge clk);
      write_reg(REG_IMAGE_WIDTH, WIDTH_PLAN[p]);
      write_reg(REG_IMAGE_HEIGHT, HEIGHT_PLAN[p]);
      if (p < 4) begin
        send_idle_pct = 38;
        recv_idle_pct = 65;
      end else if (p < 8) begin
        send_idle_pct = 65;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < PIXELS_PER_GEOMETRY; i++) begin
        // pause the sender until the block has caught up
        if (p == 6 && i == PIXELS_PER_GEOMETRY / 2) wait_drained();
        queue_pixel(rand_sample(), rand_sample(), rand_sample());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (packed_pixels_due.size() != 0)
      report_mismatch($sformatf("%0d packed pixels never arrived", packed_pixels_due.size()));

    $display("Checked %0d packed pixels over %0d image geometries and three idle patterns.",
             pixels_checked, NUM_GEOMETRIES + 2);
    $display("Geometries covered zero, oversized, unaligned and shrink-in-place sizes.");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/od332_pkg.sv
rtl/od332_quant.sv
rtl/ordered_dither_rgb332_packer_unit.sv
tb/tb_ordered_dither_rgb332_packer_unit.sv
